// ----- hw/rtl/mmb_pkg.sv -----
// ----------------------------------------------------------------------------
// mmb_pkg
// Shared types, constants and word functions of the MMB 128-bit block cipher.
// ----------------------------------------------------------------------------
package mmb_pkg;

  localparam int unsigned Rounds = 6;

  localparam logic [31:0] Delta = 32'h2AAA_AAAA;

  // index 0 sits in the low bits
  localparam logic [3:0][31:0] EncMul = {
    32'h2F8E_6D81, 32'h12F8_E6D8, 32'h04BE_39B6, 32'h025F_1CDB
  };
  localparam logic [3:0][31:0] DecMul = {
    32'h281B_5A8D, 32'h81B5_A8D2, 32'h06D6_A34A, 32'h0DAD_4694
  };

  typedef enum logic [1:0] {
    RegKeyA = 2'd0,
    RegKeyB = 2'd1,
    RegKeyC = 2'd2,
    RegKeyD = 2'd3
  } mmb_reg_e;

  typedef enum logic {
    FuncEnc = 1'b0,
    FuncDec = 1'b1
  } mmb_func_e;

  typedef logic [3:0][31:0] word_arr_t;

  typedef struct packed {
    logic        func;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } mmb_in_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } mmb_out_t;

  // block in flight between rounds
  typedef struct packed {
    logic      func;
    word_arr_t w;
  } mmb_state_t;

  function automatic word_arr_t mix_words(word_arr_t v);
    logic [31:0] e;
    logic [31:0] o;
    word_arr_t   r;
    e    = v[0] ^ v[2];
    o    = v[1] ^ v[3];
    r[0] = v[0] ^ o;
    r[1] = v[1] ^ e;
    r[2] = v[2] ^ o;
    r[3] = v[3] ^ e;
    return r;
  endfunction

  function automatic word_arr_t delta_fix(word_arr_t v);
    word_arr_t r;
    r = v;
    if (v[0][0]) begin
      r[0] = v[0] ^ Delta;
    end
    return r;
  endfunction

  // word i takes key word (i + off) mod 4
  function automatic word_arr_t key_rot(word_arr_t rk, int unsigned off);
    word_arr_t r;
    for (int unsigned i = 0; i < 4; i++) begin
      r[i] = rk[2'((i + off) & 3)];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mmb_block_cipher.sv -----
// ----------------------------------------------------------------------------
// mmb_block_cipher
// MMB 128-bit block cipher, encrypt or decrypt per item, keys over APB.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_stall_o    in_data_i  (func, 4 words)
//  output    out        out_valid_o / out_stall_i  out_data_o (4 words)
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  One item per cycle while the output is not stalled; the pipeline has
//  six rounds of four stages each, set by the 16-bit partial-product fold
//  in every lane, plus the final key add register.
//  Reset clears all valid bits and the four key words.
//  A stalled result holds in the output register; empty stages upstream
//  keep filling, and the input stalls only when every stage holds an item.
// ----------------------------------------------------------------------------
module mmb_block_cipher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mmb_pkg::mmb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mmb_pkg::mmb_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned N = mmb_pkg::Rounds;

  mmb_pkg::word_arr_t  rk_q;
  mmb_pkg::mmb_reg_e   reg_sel;
  mmb_pkg::mmb_state_t st   [N+1];
  logic                vld  [N+1];
  logic                rdy  [N+1];

  logic               out_valid_q;
  mmb_pkg::mmb_out_t  out_q;
  mmb_pkg::word_arr_t fin;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_sel = mmb_pkg::mmb_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        mmb_pkg::RegKeyA: rk_q[0] <= pwdata;
        mmb_pkg::RegKeyB: rk_q[1] <= pwdata;
        mmb_pkg::RegKeyC: rk_q[2] <= pwdata;
        mmb_pkg::RegKeyD: rk_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mmb_pkg::RegKeyA: prdata = rk_q[0];
      mmb_pkg::RegKeyB: prdata = rk_q[1];
      mmb_pkg::RegKeyC: prdata = rk_q[2];
      mmb_pkg::RegKeyD: prdata = rk_q[3];
      default:          prdata = '0;
    endcase
  end

  // ---------------- round pipeline ----------------
  assign vld[0]   = in_valid_i;
  assign st[0]    = '{func: in_data_i.func,
                      w: {in_data_i.in_word3, in_data_i.in_word2,
                          in_data_i.in_word1, in_data_i.in_word0}};
  assign in_stall_o = !rdy[0];

  for (genvar r = 0; r < N; r++) begin : g_round
    mmb_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[r]),
      .ready_o   (rdy[r]),
      .data_i    (st[r]),
      .enc_key_i (mmb_pkg::key_rot(rk_q, r)),
      .dec_key_i (mmb_pkg::key_rot(rk_q, N - r)),
      .valid_o   (vld[r+1]),
      .ready_i   (rdy[r+1]),
      .data_o    (st[r+1])
    );
  end

  // ---------------- final key add ----------------
  assign rdy[N] = !out_valid_q || !out_stall_i;
  assign fin = st[N].w ^ ((st[N].func == mmb_pkg::FuncDec) ? mmb_pkg::key_rot(rk_q, 0)
                                                           : mmb_pkg::key_rot(rk_q, N));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[N]) begin
      out_valid_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N]) begin
      out_q <= '{out_word0: fin[0], out_word1: fin[1],
                 out_word2: fin[2], out_word3: fin[3]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled while the output side moves");

  a_last_round_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[N] && rdy[N] |=> out_valid_q)
    else $error("item from the last round did not reach the output");

  a_key_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (reg_sel == mmb_pkg::RegKeyA) |=>
    rk_q[0] == $past(pwdata))
    else $error("key word write lost");
`endif

endmodule

// ----- hw/rtl/mmb_lane.sv -----
// ----------------------------------------------------------------------------
// mmb_lane
// One word lane: multiply modulo 2^32-1 with the 16-bit carry-fold sequence,
// three register stages and a short add tail.
// ----------------------------------------------------------------------------
module mmb_lane (
  input  logic        clk_i,
  input  logic [2:0]  en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  // stage 1: partial products
  logic [31:0] pll_q, phl_q, plh_q, phh_q;
  // stage 2: first fold
  logic [16:0] p2_q;
  logic [15:0] hw1_q;
  logic [31:0] plh2_q, phh2_q;
  // stage 3: second fold
  logic [31:0] p3_q;
  logic [15:0] hw2_q;

  logic [31:0] s1, s2, p3;
  logic [16:0] p2, s3;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pll_q <= a_i[15:0]  * b_i[15:0];
      phl_q <= a_i[31:16] * b_i[15:0];
      plh_q <= a_i[15:0]  * b_i[31:16];
      phh_q <= a_i[31:16] * b_i[31:16];
    end
  end

  always_comb begin
    s1 = phl_q + {16'd0, pll_q[31:16]};
    // w1 = {s1 low, pll low}; p2 = low(w1) + high(s1)
    p2 = {1'b0, pll_q[15:0]} + {1'b0, s1[31:16]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p2_q   <= p2;
      hw1_q  <= s1[15:0];
      plh2_q <= plh_q;
      phh2_q <= phh_q;
    end
  end

  always_comb begin
    s2 = plh2_q + {16'd0, hw1_q} + {31'd0, p2_q[16]};
    // w2 = {s2 low, p2 low}
    p3 = phh2_q + {16'd0, p2_q[15:0]} + {16'd0, s2[31:16]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p3_q  <= p3;
      hw2_q <= s2[15:0];
    end
  end

  // last fold; the end-around carry wraps at 32 bits
  assign s3  = {1'b0, hw2_q} + {1'b0, p3_q[31:16]};
  assign p_o = {s3[15:0], p3_q[15:0]} + {31'd0, s3[16]};

endmodule

// ----- hw/rtl/mmb_round.sv -----
// ----------------------------------------------------------------------------
// mmb_round
// One cipher round: key add, four multiply lanes and the word-merging stage,
// four pipeline stages with their own valid bits.
// ----------------------------------------------------------------------------
module mmb_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  mmb_pkg::mmb_state_t  data_i,
  input  mmb_pkg::word_arr_t   enc_key_i,
  input  mmb_pkg::word_arr_t   dec_key_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mmb_pkg::mmb_state_t  data_o
);

  logic [3:0] valid_q;
  logic [3:0] rdy;
  logic [2:0] func_q;

  mmb_pkg::word_arr_t  x, prod, y;
  mmb_pkg::mmb_state_t out_q;

  always_comb begin
    rdy[3] = !valid_q[3] || ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  // decrypt runs mix and delta ahead of the multiply
  always_comb begin
    x = data_i.w ^ ((data_i.func == mmb_pkg::FuncDec) ? dec_key_i : enc_key_i);
    if (data_i.func == mmb_pkg::FuncDec) begin
      x = mmb_pkg::delta_fix(mmb_pkg::mix_words(x));
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [31:0] mul;
    assign mul = (data_i.func == mmb_pkg::FuncDec) ? mmb_pkg::DecMul[i]
                                                   : mmb_pkg::EncMul[i];
    mmb_lane u_lane (
      .clk_i (clk_i),
      .en_i  (rdy[2:0]),
      .a_i   (x[i]),
      .b_i   (mul),
      .p_o   (prod[i])
    );
  end

  // merging stage: encrypt applies delta and mix after the multiply
  always_comb begin
    y = prod;
    if (func_q[2] == mmb_pkg::FuncEnc) begin
      y = mmb_pkg::mix_words(mmb_pkg::delta_fix(prod));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) func_q[0] <= data_i.func;
    if (rdy[1]) func_q[1] <= func_q[0];
    if (rdy[2]) func_q[2] <= func_q[1];
    if (rdy[3]) out_q <= '{func: func_q[2], w: y};
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[3];
  assign data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_full_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&valid_q))
    else $error("round refuses an item with a free stage");

  a_func_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && rdy[1] |=> valid_q[1] && (func_q[1] == $past(func_q[0])))
    else $error("operation select lost between stages");

  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && !ready_i |=> valid_q[3] && $stable(out_q))
    else $error("round output changed while held");
`endif

endmodule
